[src/icms_pkg.sv]
// Shared constants, types and saturation helper for the inertial camera motion step block.
`default_nettype none

package icms_pkg;

    localparam int NUM_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int WIDE_W    = 64;
    localparam int MUL_BITS  = 34;
    localparam int DIV_BITS  = 35;
    localparam int DIV_STEPS = 64;
    localparam int ACC_W     = WIDE_W + MUL_BITS;
    localparam int CNT_W     = 7;
    localparam int CFG_W     = 31;
    localparam int DT_W      = 16;
    localparam int ADDR_W    = 5;

    localparam logic [WIDE_W-1:0] MAG_CAP = 64'h4000_0000_0000_0000;
    localparam logic signed [WIDE_W-1:0] NUM_MAX = (64'sd1 <<< (NUM_W - 1)) - 64'sd1;
    localparam logic signed [WIDE_W-1:0] NUM_MIN = -NUM_MAX - 64'sd1;
    localparam logic [WIDE_W-1:0] SLEW_COEF = 64'(3 * ((2 ** FRAC_W) / 4));
    localparam logic signed [NUM_W-1:0] POS_Z_RESET = NUM_W'(20 * (2 ** FRAC_W));

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_MOVE = 2'd1;
    localparam logic [1:0] KIND_KICK = 2'd2;

    localparam logic [2:0] REG_PAN_DECEL  = 3'd0;
    localparam logic [2:0] REG_ZOOM_DECEL = 3'd1;
    localparam logic [2:0] REG_SLEW_EN    = 3'd2;
    localparam logic [2:0] REG_SLEW_GAIN  = 3'd3;
    localparam logic [2:0] REG_XY_LIMIT   = 3'd4;
    localparam logic [2:0] REG_Z_MIN      = 3'd5;
    localparam logic [2:0] REG_Z_MAX      = 3'd6;

    typedef enum logic {MDU_MUL, MDU_DIV} mdu_op_t;

    typedef struct packed {
        logic                     start;
        mdu_op_t                  op;
        logic signed [WIDE_W-1:0] a;
        logic signed [WIDE_W-1:0] b;
    } mdu_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [WIDE_W-1:0] res;
    } mdu_rsp_t;

    function automatic logic signed [NUM_W-1:0] sat_num(input logic signed [WIDE_W-1:0] x);
        logic signed [NUM_W-1:0] r;
        if (x > NUM_MAX)
        begin
            r = NUM_MAX[NUM_W-1:0];
        end
        else if (x < NUM_MIN)
        begin
            r = NUM_MIN[NUM_W-1:0];
        end
        else
        begin
            r = x[NUM_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/inertial_camera_motion_step.sv]
// Top level: camera motion state, APB registers and the sequencer around the shared unit.
//
//  channel | signals                                         | direction
//  item    | item_valid/item_ready, kind..move_duration      | in
//  result  | res_valid/res_ready, out_pos_*, out_look_*, mov | out
//  config  | APB psel/penable/pwrite/paddr/pwdata/prdata     | in/out
//
// Move, add-velocity and unused items are applied in S_IDLE and posted from S_FIN; a tick runs the sequence below.
// A tick is a chain of 34-step multiplies and 64-step divides on the one shared unit;
// a decelerating axis costs up to two divides and two multiplies.
// item_ready is low from the accepted transaction until its result is posted; a posted
// result waits in the output register while the next item is taken.
// Reset is asynchronous and restores position (0, 0, 20.0) and all register defaults.
`default_nettype none

module inertial_camera_motion_step (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [icms_pkg::ADDR_W-1:0]           paddr,
    input  wire logic [31:0]                           pwdata,
    output logic      [31:0]                           prdata,
    output logic                                       pready,
    input  wire logic                                  item_valid,
    output logic                                       item_ready,
    input  wire logic [1:0]                            kind,
    input  wire logic [icms_pkg::DT_W-1:0]             step_time,
    input  wire logic signed [icms_pkg::NUM_W-1:0]     value_x,
    input  wire logic signed [icms_pkg::NUM_W-1:0]     value_y,
    input  wire logic signed [icms_pkg::NUM_W-1:0]     value_z,
    input  wire logic [icms_pkg::CFG_W-1:0]            move_duration,
    output logic                                       res_valid,
    input  wire logic                                  res_ready,
    output logic signed [icms_pkg::NUM_W-1:0]          out_pos_x,
    output logic signed [icms_pkg::NUM_W-1:0]          out_pos_y,
    output logic signed [icms_pkg::NUM_W-1:0]          out_pos_z,
    output logic signed [icms_pkg::NUM_W-1:0]          out_look_x,
    output logic signed [icms_pkg::NUM_W-1:0]          out_look_y,
    output logic                                       moving
);
    import icms_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_TICK, S_MV_GO, S_MV_WT, S_AX_GO, S_AX_VV, S_AX_QGO, S_AX_Q,
        S_AX_DIST, S_AX_DW, S_AX_MGO, S_AX_M, S_IN_GO, S_IN_WT, S_SG_GO, S_SG_WT,
        S_SL_GO, S_SL_WT, S_FIN
    } state_t;

    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    state_t state_reg;
    logic [1:0] ax_reg;

    logic [CFG_W-1:0] pan_decel_reg;
    logic [CFG_W-1:0] zoom_decel_reg;
    logic             slew_enable_reg;
    logic [CFG_W-1:0] slew_gain_reg;
    logic [CFG_W-1:0] xy_limit_reg;
    logic [CFG_W-1:0] z_min_reg;
    logic [CFG_W-1:0] z_max_reg;

    logic signed [NUM_W-1:0] pos_reg [3];
    logic signed [NUM_W-1:0] vel_reg [3];
    logic signed [NUM_W-1:0] tgt_reg [3];
    logic signed [NUM_W-1:0] slew_reg [2];
    logic signed [NUM_W-1:0] look_reg [2];
    logic [CFG_W-1:0]        time_left_reg;
    logic [DT_W-1:0]         dt_reg;
    logic signed [WIDE_W-1:0] vv_reg;
    logic signed [WIDE_W-1:0] d_reg;
    logic signed [NUM_W-1:0]  goal_reg;

    logic                    res_valid_reg;
    logic signed [NUM_W-1:0] o_pos_x_reg;
    logic signed [NUM_W-1:0] o_pos_y_reg;
    logic signed [NUM_W-1:0] o_pos_z_reg;
    logic signed [NUM_W-1:0] o_look_x_reg;
    logic signed [NUM_W-1:0] o_look_y_reg;
    logic                    o_moving_reg;

    mdu_req_t mreq;
    mdu_rsp_t mrsp;

    logic cfg_wr;
    logic signed [WIDE_W-1:0] p_w, v_w, t_w, s_w, dcfg, lo, hi, gap_w, dt_w, nv, nv_cl, mres;
    logic v_pos, over_q, snap;
    logic signed [CFG_W+1:0] tl_dec;

    icms_mdu u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[ADDR_W-1:2])
            REG_PAN_DECEL:  prdata = {1'b0, pan_decel_reg};
            REG_ZOOM_DECEL: prdata = {1'b0, zoom_decel_reg};
            REG_SLEW_EN:    prdata = {31'b0, slew_enable_reg};
            REG_SLEW_GAIN:  prdata = {1'b0, slew_gain_reg};
            REG_XY_LIMIT:   prdata = {1'b0, xy_limit_reg};
            REG_Z_MIN:      prdata = {1'b0, z_min_reg};
            REG_Z_MAX:      prdata = {1'b0, z_max_reg};
            default:        prdata = 32'b0;
        endcase
    end

    assign p_w  = WIDE_W'(pos_reg[ax_reg]);
    assign v_w  = WIDE_W'(vel_reg[ax_reg]);
    assign t_w  = WIDE_W'(tgt_reg[ax_reg]);
    assign s_w  = WIDE_W'(slew_reg[ax_reg[0]]);
    assign dt_w = $signed({{(WIDE_W-DT_W){1'b0}}, dt_reg});
    assign mres = mrsp.res;
    assign dcfg = $signed({{(WIDE_W-CFG_W){1'b0}},
                           (ax_reg == AX_Z) ? zoom_decel_reg : pan_decel_reg});
    assign lo   = (ax_reg == AX_Z) ? $signed({{(WIDE_W-CFG_W){1'b0}}, z_min_reg})
                                   : -$signed({{(WIDE_W-CFG_W){1'b0}}, xy_limit_reg});
    assign hi   = $signed({{(WIDE_W-CFG_W){1'b0}},
                           (ax_reg == AX_Z) ? z_max_reg : xy_limit_reg});
    assign v_pos  = (v_w > 0);
    assign gap_w  = v_pos ? (hi - p_w) : (p_w - lo);
    assign over_q = v_pos ? ((p_w + mres) > hi) : ((p_w - mres) < lo);
    assign nv     = v_pos ? (v_w - mres) : (v_w + mres);
    assign tl_dec = $signed({2'b0, time_left_reg}) - $signed({{(CFG_W+2-DT_W){1'b0}}, dt_reg});
    assign snap   = (tl_dec <= $signed({{(CFG_W+2-DT_W){1'b0}}, dt_reg}));

    always_comb
    begin
        if (v_pos)
        begin
            nv_cl = (nv < 0) ? '0 : nv;
        end
        else
        begin
            nv_cl = (nv > 0) ? '0 : nv;
        end
    end

    always_comb
    begin
        mreq.start = 1'b0;
        mreq.op    = MDU_MUL;
        mreq.a     = '0;
        mreq.b     = '0;
        case (state_reg)
            S_MV_GO:
            begin
                mreq.start = 1'b1;
                mreq.op    = MDU_DIV;
                mreq.a     = (t_w - p_w) <<< 1;
                mreq.b     = $signed({{(WIDE_W-CFG_W){1'b0}}, time_left_reg});
            end
            S_AX_GO:
            begin
                mreq.start = (v_w != 0);
                mreq.a     = v_w;
                mreq.b     = v_w;
            end
            S_AX_QGO:
            begin
                mreq.start = 1'b1;
                mreq.op    = MDU_DIV;
                mreq.a     = vv_reg;
                mreq.b     = dcfg <<< 1;
            end
            S_AX_DIST:
            begin
                mreq.start = (gap_w > 0);
                mreq.op    = MDU_DIV;
                mreq.a     = vv_reg;
                mreq.b     = gap_w <<< 1;
            end
            S_AX_MGO:
            begin
                mreq.start = 1'b1;
                mreq.a     = d_reg;
                mreq.b     = dt_w;
            end
            S_IN_GO:
            begin
                mreq.start = 1'b1;
                mreq.a     = v_w;
                mreq.b     = dt_w;
            end
            S_SG_GO:
            begin
                mreq.start = 1'b1;
                mreq.a     = v_w;
                mreq.b     = $signed({{(WIDE_W-CFG_W){1'b0}}, slew_gain_reg});
            end
            S_SL_GO:
            begin
                mreq.start = 1'b1;
                mreq.a     = WIDE_W'(goal_reg) - s_w;
                mreq.b     = $signed(SLEW_COEF);
            end
            default:
            begin
                mreq.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ax_reg          <= '0;
            pan_decel_reg   <= CFG_W'(65536);
            zoom_decel_reg  <= CFG_W'(65536);
            slew_enable_reg <= 1'b0;
            slew_gain_reg   <= CFG_W'(65536);
            xy_limit_reg    <= CFG_W'(65536);
            z_min_reg       <= CFG_W'(6554);
            z_max_reg       <= CFG_W'(32768000);
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                tgt_reg[i] <= '0;
            end
            pos_reg[AX_Z] <= POS_Z_RESET;
            for (int i = 0; i < 2; i++)
            begin
                slew_reg[i] <= '0;
                look_reg[i] <= '0;
            end
            time_left_reg <= '0;
            dt_reg        <= '0;
            vv_reg        <= '0;
            d_reg         <= '0;
            goal_reg      <= '0;
            res_valid_reg <= 1'b0;
            o_pos_x_reg   <= '0;
            o_pos_y_reg   <= '0;
            o_pos_z_reg   <= '0;
            o_look_x_reg  <= '0;
            o_look_y_reg  <= '0;
            o_moving_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_PAN_DECEL:  pan_decel_reg   <= pwdata[CFG_W-1:0];
                    REG_ZOOM_DECEL: zoom_decel_reg  <= pwdata[CFG_W-1:0];
                    REG_SLEW_EN:    slew_enable_reg <= pwdata[0];
                    REG_SLEW_GAIN:  slew_gain_reg   <= pwdata[CFG_W-1:0];
                    REG_XY_LIMIT:   xy_limit_reg    <= pwdata[CFG_W-1:0];
                    REG_Z_MIN:      z_min_reg       <= pwdata[CFG_W-1:0];
                    REG_Z_MAX:      z_max_reg       <= pwdata[CFG_W-1:0];
                    default:        ;
                endcase
            end

            if (res_valid_reg && res_ready && (state_reg != S_FIN))
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        state_reg <= S_FIN;
                        case (kind)
                            KIND_TICK:
                            begin
                                dt_reg    <= step_time;
                                state_reg <= S_TICK;
                            end
                            KIND_MOVE:
                            begin
                                tgt_reg[0]    <= value_x;
                                tgt_reg[1]    <= value_y;
                                tgt_reg[2]    <= value_z;
                                time_left_reg <= move_duration;
                            end
                            KIND_KICK:
                            begin
                                vel_reg[0] <= sat_num(WIDE_W'(vel_reg[0]) + WIDE_W'(value_x));
                                vel_reg[1] <= sat_num(WIDE_W'(vel_reg[1]) + WIDE_W'(value_y));
                            end
                            default: ;
                        endcase
                    end
                end
                S_TICK:
                begin
                    ax_reg <= '0;
                    if (time_left_reg != '0)
                    begin
                        if (snap)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                pos_reg[i] <= tgt_reg[i];
                                vel_reg[i] <= '0;
                            end
                            time_left_reg <= '0;
                            state_reg     <= S_IN_GO;
                        end
                        else
                        begin
                            state_reg <= S_MV_GO;
                        end
                    end
                    else
                    begin
                        state_reg <= S_AX_GO;
                    end
                end
                S_MV_GO:
                begin
                    state_reg <= S_MV_WT;
                end
                S_MV_WT:
                begin
                    if (mrsp.done)
                    begin
                        vel_reg[ax_reg] <= sat_num(mres);
                        if (ax_reg == AX_Z)
                        begin
                            time_left_reg <= tl_dec[CFG_W-1:0];
                            ax_reg        <= '0;
                            state_reg     <= S_IN_GO;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_MV_GO;
                        end
                    end
                end
                S_AX_GO:
                begin
                    if (v_w != 0)
                    begin
                        state_reg <= S_AX_VV;
                    end
                    else if (ax_reg == AX_Z)
                    begin
                        ax_reg    <= '0;
                        state_reg <= S_IN_GO;
                    end
                    else
                    begin
                        ax_reg <= ax_reg + 2'd1;
                    end
                end
                S_AX_VV:
                begin
                    if (mrsp.done)
                    begin
                        vv_reg    <= mres;
                        state_reg <= (dcfg == 0) ? S_AX_DIST : S_AX_QGO;
                    end
                end
                S_AX_QGO:
                begin
                    state_reg <= S_AX_Q;
                end
                S_AX_Q:
                begin
                    if (mrsp.done)
                    begin
                        if (over_q)
                        begin
                            state_reg <= S_AX_DIST;
                        end
                        else
                        begin
                            d_reg     <= dcfg;
                            state_reg <= S_AX_MGO;
                        end
                    end
                end
                S_AX_DIST:
                begin
                    if (gap_w > 0)
                    begin
                        state_reg <= S_AX_DW;
                    end
                    else
                    begin
                        vel_reg[ax_reg] <= '0;
                        if (ax_reg == AX_Z)
                        begin
                            ax_reg    <= '0;
                            state_reg <= S_IN_GO;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_AX_GO;
                        end
                    end
                end
                S_AX_DW:
                begin
                    if (mrsp.done)
                    begin
                        d_reg     <= mres;
                        state_reg <= S_AX_MGO;
                    end
                end
                S_AX_MGO:
                begin
                    state_reg <= S_AX_M;
                end
                S_AX_M:
                begin
                    if (mrsp.done)
                    begin
                        vel_reg[ax_reg] <= sat_num(nv_cl);
                        if (ax_reg == AX_Z)
                        begin
                            ax_reg    <= '0;
                            state_reg <= S_IN_GO;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_AX_GO;
                        end
                    end
                end
                S_IN_GO:
                begin
                    state_reg <= S_IN_WT;
                end
                S_IN_WT:
                begin
                    if (mrsp.done)
                    begin
                        pos_reg[ax_reg] <= sat_num(p_w + mres);
                        if (ax_reg == AX_Z)
                        begin
                            ax_reg <= '0;
                            if (slew_enable_reg)
                            begin
                                state_reg <= S_SG_GO;
                            end
                            else
                            begin
                                look_reg[0] <= pos_reg[0];
                                look_reg[1] <= pos_reg[1];
                                state_reg   <= S_FIN;
                            end
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_IN_GO;
                        end
                    end
                end
                S_SG_GO:
                begin
                    state_reg <= S_SG_WT;
                end
                S_SG_WT:
                begin
                    if (mrsp.done)
                    begin
                        goal_reg  <= sat_num(mres);
                        state_reg <= S_SL_GO;
                    end
                end
                S_SL_GO:
                begin
                    state_reg <= S_SL_WT;
                end
                S_SL_WT:
                begin
                    if (mrsp.done)
                    begin
                        slew_reg[ax_reg[0]] <= sat_num(s_w + mres);
                        look_reg[ax_reg[0]] <= sat_num(p_w + WIDE_W'(sat_num(s_w + mres)));
                        if (ax_reg == AX_Y)
                        begin
                            ax_reg    <= '0;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_SG_GO;
                        end
                    end
                end
                S_FIN:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_valid_reg <= 1'b1;
                        o_pos_x_reg   <= pos_reg[0];
                        o_pos_y_reg   <= pos_reg[1];
                        o_pos_z_reg   <= pos_reg[2];
                        o_look_x_reg  <= look_reg[0];
                        o_look_y_reg  <= look_reg[1];
                        o_moving_reg  <= (time_left_reg != '0);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = res_valid_reg;
    assign out_pos_x  = o_pos_x_reg;
    assign out_pos_y  = o_pos_y_reg;
    assign out_pos_z  = o_pos_z_reg;
    assign out_look_x = o_look_x_reg;
    assign out_look_y = o_look_y_reg;
    assign moving     = o_moving_reg;

endmodule

`default_nettype wire

[src/icms_mdu.sv]
// Iterative shared multiply/divide unit: Q16.16 signed product or quotient, magnitude capped.
`default_nettype none

module icms_mdu (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire icms_pkg::mdu_req_t req,
    output icms_pkg::mdu_rsp_t    rsp
);
    import icms_pkg::*;

    logic                     busy_reg;
    logic [CNT_W-1:0]         cnt_reg;
    mdu_op_t                  op_reg;
    logic                     neg_reg;
    logic                     dz_reg;
    logic [WIDE_W-1:0]        ma_reg;
    logic [WIDE_W-1:0]        mb_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [DIV_BITS-1:0]      rem_reg;
    logic                     done_reg;
    logic signed [WIDE_W-1:0] res_reg;

    logic [WIDE_W-1:0]   a_mag;
    logic [WIDE_W-1:0]   b_mag;
    logic [ACC_W-1:0]    mul_add;
    logic [DIV_BITS:0]   rem_sh;
    logic [DIV_BITS:0]   dvs;
    logic                div_ge;
    logic [DIV_BITS:0]   rem_new;
    logic [ACC_W-1:0]    raw_mag;
    logic [WIDE_W-1:0]   cap_mag;
    logic signed [WIDE_W-1:0] fin_res;

    assign a_mag   = req.a[WIDE_W-1] ? WIDE_W'(-req.a) : WIDE_W'(req.a);
    assign b_mag   = req.b[WIDE_W-1] ? WIDE_W'(-req.b) : WIDE_W'(req.b);
    assign mul_add = {acc_reg[ACC_W-2:0], 1'b0}
                   + (mb_reg[MUL_BITS-1] ? {{MUL_BITS{1'b0}}, ma_reg} : {ACC_W{1'b0}});
    assign rem_sh  = {rem_reg, ma_reg[WIDE_W-1]};
    assign dvs     = {1'b0, mb_reg[DIV_BITS-1:0]};
    assign div_ge  = (rem_sh >= dvs);
    assign rem_new = div_ge ? (rem_sh - dvs) : rem_sh;

    always_comb
    begin
        if (op_reg == MDU_MUL)
        begin
            raw_mag = acc_reg >> FRAC_W;
        end
        else if (dz_reg)
        begin
            raw_mag = {{MUL_BITS{1'b0}}, MAG_CAP};
        end
        else
        begin
            raw_mag = {{MUL_BITS{1'b0}}, acc_reg[WIDE_W-1:0]};
        end
        cap_mag = (raw_mag > {{MUL_BITS{1'b0}}, MAG_CAP}) ? MAG_CAP : raw_mag[WIDE_W-1:0];
        fin_res = neg_reg ? -$signed(cap_mag) : $signed(cap_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= MDU_MUL;
            neg_reg  <= 1'b0;
            dz_reg   <= 1'b0;
            ma_reg   <= '0;
            mb_reg   <= '0;
            acc_reg  <= '0;
            rem_reg  <= '0;
            done_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                neg_reg  <= req.a[WIDE_W-1] ^ req.b[WIDE_W-1];
                dz_reg   <= (req.b == '0);
                mb_reg   <= b_mag;
                acc_reg  <= '0;
                rem_reg  <= '0;
                if (req.op == MDU_MUL)
                begin
                    cnt_reg <= CNT_W'(MUL_BITS);
                    ma_reg  <= a_mag;
                end
                else
                begin
                    cnt_reg <= CNT_W'(DIV_STEPS);
                    ma_reg  <= {a_mag[WIDE_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
                end
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                    if (op_reg == MDU_MUL)
                    begin
                        acc_reg <= mul_add;
                        mb_reg  <= mb_reg << 1;
                    end
                    else
                    begin
                        rem_reg <= rem_new[DIV_BITS-1:0];
                        ma_reg  <= ma_reg << 1;
                        acc_reg <= {acc_reg[ACC_W-2:0], div_ge};
                    end
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    res_reg  <= fin_res;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

`default_nettype wire

[src/icms_check.sv]
// Port-level assertions for the camera motion step block, bound to the top level.
`default_nettype none

module icms_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_valid,
    input wire logic        item_ready,
    input wire logic [1:0]  kind,
    input wire logic [30:0] move_duration,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [31:0] out_pos_x,
    input wire logic        moving
);
    import icms_pkg::*;

    // one transaction at a time: ready drops after every accepted item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item_ready stayed high after an accepted transaction");

    // ready only comes back together with a posted result
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(item_ready) |-> res_valid)
        else $error("item_ready returned without a posted result");

    // a move reports its moving flag from the loaded duration
    a_move_flag: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && kind == KIND_MOVE && (!res_valid || res_ready)
        |=> ##1 res_valid && (moving == ($past(move_duration, 2) != 31'd0)))
        else $error("move transaction gave a wrong moving flag");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_pos_x))
        else $error("posted result changed before it was taken");

endmodule

bind inertial_camera_motion_step icms_check u_icms_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .kind          (kind),
    .move_duration (move_duration),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .out_pos_x     (out_pos_x),
    .moving        (moving)
);

`default_nettype wire
